// File: rtl/core/lattice_agent_fitness_defines.svh
// Assertion helpers used by laf_ctrl. Each expects clk and rst_n in scope.
`ifndef LATTICE_AGENT_FITNESS_DEFINES_SVH
`define LATTICE_AGENT_FITNESS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LAF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/laf_pkg.sv
package laf_pkg;

  localparam int SIDE  = 64;
  localparam int BITS  = 16;
  localparam int CELLS = SIDE * SIDE;

  localparam int COORD_W   = $clog2(SIDE);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int BIT_IDX_W = $clog2(BITS);
  localparam int POP_W     = $clog2(CELLS) + 1;
  localparam int ONES_W    = $clog2(BITS + 1);

  // Field widths of the stream items.
  localparam int ROW_IN_W  = 6;
  localparam int STR_IN_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int FIT_W     = 25;
  localparam int DIST_W    = 17;
  localparam int OVL_W     = 7;

  localparam int IN_FIELDS_W  = 2 * ROW_IN_W + STR_IN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = FIT_W + DIST_W + OVL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Distance sum is accumulated over a fixed number of steps, several bits a step.
  localparam int DIST_STEPS  = 4;
  localparam int DIST_LANES  = BITS / DIST_STEPS;
  localparam int DSTEP_W     = $clog2(DIST_STEPS);
  localparam int LANE_W      = BIT_IDX_W - DSTEP_W;

  // fitness = (G*D) >> GD_SHIFT + (A*S) << LA_SHIFT, exact for powers of two.
  localparam int GD_W     = WEIGHT_W + DIST_W;
  localparam int LA_W     = WEIGHT_W + OVL_W;
  localparam int GD_SHIFT = $clog2(BITS * CELLS) - 8;
  localparam int LA_SHIFT = 6 - $clog2(BITS);

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL  = 1'b1;

  // Operation codes carried in tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Memory address selection.
  localparam int ASEL_W = 3;
  localparam logic [ASEL_W-1:0] ASEL_SELF  = 3'd0;
  localparam logic [ASEL_W-1:0] ASEL_DOWN  = 3'd1;
  localparam logic [ASEL_W-1:0] ASEL_UP    = 3'd2;
  localparam logic [ASEL_W-1:0] ASEL_RIGHT = 3'd3;
  localparam logic [ASEL_W-1:0] ASEL_LEFT  = 3'd4;
  localparam logic [ASEL_W-1:0] ASEL_CLEAR = 3'd5;

  typedef struct packed {
    logic              capture;
    logic              mem_we;
    logic              wr_zero;
    logic [ASEL_W-1:0] addr_sel;
    logic [ADDR_W-1:0] clr_addr;
    logic              take_self;
    logic              ovl_acc;
    logic              dist_acc;
    logic              pop_update;
    logic              mul;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  function automatic logic [ONES_W-1:0] ones(input logic [BITS-1:0] v);
    logic [ONES_W-1:0] n;
    n = '0;
    for (int i = 0; i < BITS; i++) begin
      n = n + ONES_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/lattice_agent_fitness.sv
// Lattice agent fitness engine.
// Input channel (in_*): one beat per item. tuser is the operation: a load writes
// bit_string into the addressed cell and updates the per-bit population counts;
// an evaluate returns one output beat with fitness, distance sum and overlap sum.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 global
// weight, 1 local weight) at the clock edge; write only while the block is idle.
// A load goes from the accept cycle to a read of the old cell contents, then to a
// write of the new string that also updates the counts. An evaluate goes from the
// accept cycle through reads of the cell and its four neighbors, which come through
// the one read port of the cell store at one read per cycle; the last neighbor is
// folded in, then a multiply step and a combine step follow. No new item is taken until the block is back in idle.
// Reset (rst_n low, synchronous) sets both weights to 1.0 and clears the counts,
// then a clearing pass writes zero to all 4096 cells, one per cycle; in_tready
// stays low for the whole pass. A finished result waits in the output register
// while out_tready is low; the next item is still taken, and an evaluate holds in
// its last cycle until the waiting beat has been taken.
module lattice_agent_fitness (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [laf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [laf_pkg::WEIGHT_W-1:0]    cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] row, [11:6] column, [27:12] bit_string, [31:28] zero
  input  logic [laf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [24:0] fitness, [41:25] distance_sum, [48:42] overlap_sum, [55:49] zero
  output logic [laf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import laf_pkg::*;

  cmd_t    cmd;
  status_t status;

  laf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  laf_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/core/laf_datapath.sv
module laf_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [laf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [laf_pkg::WEIGHT_W-1:0]   cfg_wdata,
  input  logic [laf_pkg::IN_TDATA_W-1:0] in_tdata,
  input  laf_pkg::cmd_t                  cmd,
  output laf_pkg::status_t               status,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [laf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import laf_pkg::*;

  logic [COORD_W-1:0]  row_r, col_r;
  logic [BITS-1:0]     str_r;
  logic [COORD_W-1:0]  row_dn, row_up, col_rt, col_lt;
  logic [ADDR_W-1:0]   mem_addr;
  logic [BITS-1:0]     mem_wdata;
  logic [BITS-1:0]     mem [CELLS];
  logic [BITS-1:0]     rdata_r;
  logic [BITS-1:0]     self_r;
  logic [OVL_W-1:0]    ovl_r;
  logic [DIST_W-1:0]   dist_r, dist_add;
  logic [DSTEP_W-1:0]  dstep_r;
  logic [POP_W-1:0]    pop_r   [BITS];
  logic [POP_W-1:0]    pop_nxt [BITS];
  logic [BIT_IDX_W-1:0] lane_bit [DIST_LANES];
  logic [WEIGHT_W-1:0] gw_r, lw_r;
  logic [GD_W-1:0]     gd_r;
  logic [LA_W-1:0]     la_r;
  logic [FIT_W:0]      fit_sum;
  logic [FIT_W-1:0]    fit_sat;
  logic                out_valid_r;
  logic [FIT_W-1:0]    out_fit_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic [OVL_W-1:0]    out_ovl_r;

  // Weights.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= WEIGHT_RESET;
      lw_r <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GLOBAL: gw_r <= cfg_wdata;
        CFG_LOCAL:  lw_r <= cfg_wdata;
      endcase
    end
  end

  // Item capture; coordinates are reduced modulo the lattice side.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_tdata[COORD_W-1:0];
      col_r <= in_tdata[ROW_IN_W +: COORD_W];
      str_r <= in_tdata[2*ROW_IN_W +: BITS];
    end
  end

  assign row_dn = row_r + COORD_W'(1);
  assign row_up = row_r - COORD_W'(1);
  assign col_rt = col_r + COORD_W'(1);
  assign col_lt = col_r - COORD_W'(1);

  always_comb begin
    unique case (cmd.addr_sel)
      ASEL_SELF:  mem_addr = {row_r, col_r};
      ASEL_DOWN:  mem_addr = {row_dn, col_r};
      ASEL_UP:    mem_addr = {row_up, col_r};
      ASEL_RIGHT: mem_addr = {row_r, col_rt};
      ASEL_LEFT:  mem_addr = {row_r, col_lt};
      ASEL_CLEAR: mem_addr = cmd.clr_addr;
      default:    mem_addr = {row_r, col_r};
    endcase
  end

  assign mem_wdata = cmd.wr_zero ? '0 : str_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // Population counts follow every load: drop the old bits, add the new ones.
  always_comb begin
    for (int b = 0; b < BITS; b++) begin
      pop_nxt[b] = pop_r[b];
      if (cmd.pop_update) begin
        pop_nxt[b] = pop_r[b] - POP_W'(rdata_r[b]) + POP_W'(str_r[b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < BITS; b++) begin
        pop_r[b] <= '0;
      end
    end else begin
      for (int b = 0; b < BITS; b++) begin
        pop_r[b] <= pop_nxt[b];
      end
    end
  end

  // One group of bits of the distance sum per step.
  always_comb begin
    dist_add = '0;
    for (int l = 0; l < DIST_LANES; l++) begin
      lane_bit[l] = {dstep_r, LANE_W'(l)};
      if (self_r[lane_bit[l]]) begin
        dist_add = dist_add + DIST_W'(POP_W'(CELLS) - pop_r[lane_bit[l]]);
      end else begin
        dist_add = dist_add + DIST_W'(pop_r[lane_bit[l]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_self) begin
      self_r <= rdata_r;
    end
    if (cmd.capture) begin
      ovl_r   <= '0;
      dist_r  <= '0;
      dstep_r <= '0;
    end else begin
      if (cmd.ovl_acc) begin
        ovl_r <= ovl_r + OVL_W'(ones(self_r & rdata_r));
      end
      if (cmd.dist_acc) begin
        dist_r  <= dist_r + dist_add;
        dstep_r <= dstep_r + DSTEP_W'(1);
      end
    end
    if (cmd.mul) begin
      gd_r <= GD_W'(gw_r) * GD_W'(dist_r);
      la_r <= LA_W'(lw_r) * LA_W'(ovl_r);
    end
  end

  assign fit_sum = (FIT_W + 1)'(gd_r >> GD_SHIFT) + ((FIT_W + 1)'(la_r) << LA_SHIFT);
  assign fit_sat = fit_sum[FIT_W] ? '1 : fit_sum[FIT_W-1:0];

  // Output register: a result may wait here while the next item is taken in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fit_r  <= fit_sat;
      out_dist_r <= dist_r;
      out_ovl_r  <= ovl_r;
    end
  end

  assign status.out_busy = out_valid_r & ~out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_ovl_r, out_dist_r, out_fit_r};

endmodule

// File: rtl/core/laf_ctrl.sv
`include "lattice_agent_fitness_defines.svh"

module laf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tuser,
  output logic             in_tready,
  input  laf_pkg::status_t status,
  output laf_pkg::cmd_t    cmd
);
  import laf_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_CLEAR   = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE    = 4'd1;
  localparam logic [ST_W-1:0] ST_LD_RD   = 4'd2;
  localparam logic [ST_W-1:0] ST_LD_WR   = 4'd3;
  localparam logic [ST_W-1:0] ST_EV_SELF = 4'd4;
  localparam logic [ST_W-1:0] ST_EV_DN   = 4'd5;
  localparam logic [ST_W-1:0] ST_EV_UP   = 4'd6;
  localparam logic [ST_W-1:0] ST_EV_RT   = 4'd7;
  localparam logic [ST_W-1:0] ST_EV_LT   = 4'd8;
  localparam logic [ST_W-1:0] ST_EV_LAST = 4'd9;
  localparam logic [ST_W-1:0] ST_EV_MUL  = 4'd10;
  localparam logic [ST_W-1:0] ST_EV_EMIT = 4'd11;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.addr_sel = ASEL_SELF;
    cmd.clr_addr = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.mem_we   = 1'b1;
        cmd.wr_zero  = 1'b1;
        cmd.addr_sel = ASEL_CLEAR;
        clr_cnt_nxt  = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_tuser == OP_LOAD) ? ST_LD_RD : ST_EV_SELF;
        end
      end
      ST_LD_RD: begin
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd.mem_we     = 1'b1;
        cmd.pop_update = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_EV_SELF: begin
        state_nxt = ST_EV_DN;
      end
      ST_EV_DN: begin
        cmd.take_self = 1'b1;
        cmd.addr_sel  = ASEL_DOWN;
        state_nxt     = ST_EV_UP;
      end
      // From here on, each cycle folds in the neighbor that the previous cycle read.
      ST_EV_UP: begin
        cmd.addr_sel = ASEL_UP;
        cmd.ovl_acc  = 1'b1;
        cmd.dist_acc = 1'b1;
        state_nxt    = ST_EV_RT;
      end
      ST_EV_RT: begin
        cmd.addr_sel = ASEL_RIGHT;
        cmd.ovl_acc  = 1'b1;
        cmd.dist_acc = 1'b1;
        state_nxt    = ST_EV_LT;
      end
      ST_EV_LT: begin
        cmd.addr_sel = ASEL_LEFT;
        cmd.ovl_acc  = 1'b1;
        cmd.dist_acc = 1'b1;
        state_nxt    = ST_EV_LAST;
      end
      ST_EV_LAST: begin
        cmd.ovl_acc  = 1'b1;
        cmd.dist_acc = 1'b1;
        state_nxt    = ST_EV_MUL;
      end
      ST_EV_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EV_EMIT;
      end
      ST_EV_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `LAF_ASSERT_IMP(a_no_accept_in_clear, state_r == ST_CLEAR, !in_tready, "item taken during clearing pass")
  `LAF_ASSERT_IMP(a_write_source, cmd.mem_we, (state_r == ST_CLEAR) || (state_r == ST_LD_WR), "store written outside clear or load")
  `LAF_ASSERT_NXT(a_clear_ends, (state_r == ST_CLEAR) && (clr_cnt_r == '1), state_r == ST_IDLE, "clearing pass did not finish")
  `LAF_ASSERT_IMP(a_emit_free, cmd.emit, !status.out_busy, "result overwrote a waiting beat")

endmodule

// File: tb/lattice_agent_fitness_tb.sv
module lattice_agent_fitness_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import laf_pkg::*;

  localparam longint unsigned FIT_CAP = (64'd1 << FIT_W) - 1;

  typedef struct packed {
    logic [FIT_W-1:0]  fitness;
    logic [DIST_W-1:0] distance;
    logic [OVL_W-1:0]  overlap;
  } eval_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_GLOBAL;
  logic [WEIGHT_W-1:0]    cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = OP_LOAD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Mirror of the lattice, the per-bit counts and the two weights.
  logic [STR_IN_W-1:0] lattice [CELLS];
  logic [12:0]         bit_pop [BITS];
  logic [WEIGHT_W-1:0] weight_g = WEIGHT_RESET;
  logic [WEIGHT_W-1:0] weight_a = WEIGHT_RESET;

  eval_result_t pending [$];
  int           errors = 0;
  bit           no_idle = 1'b0;

  lattice_agent_fitness dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("lattice_agent_fitness_tb: errors");
    $finish;
  end

  initial begin
    foreach (lattice[i]) lattice[i] = '0;
    foreach (bit_pop[i]) bit_pop[i] = '0;
  end

  function automatic eval_result_t predict_fitness(input logic [5:0] r, input logic [5:0] c);
    logic [STR_IN_W-1:0] self_str;
    int unsigned         dist_sum;
    int unsigned         ovl;
    longint unsigned     num;
    longint unsigned     fit;
    self_str = lattice[{r, c}];
    dist_sum = 0;
    for (int b = 0; b < BITS; b++) begin
      if (self_str[b]) begin
        dist_sum += CELLS - bit_pop[b];
      end else begin
        dist_sum += bit_pop[b];
      end
    end
    // Neighbors wrap around the torus through 6-bit coordinate arithmetic.
    ovl = $countones(self_str & lattice[{r + 6'd1, c}])
        + $countones(self_str & lattice[{r - 6'd1, c}])
        + $countones(self_str & lattice[{r, c + 6'd1}])
        + $countones(self_str & lattice[{r, c - 6'd1}]);
    num = 64'(weight_g) * dist_sum * 64'd256 + 64'(weight_a) * ovl * 64'd64 * 64'(CELLS);
    fit = num / (64'(BITS) * 64'(CELLS));
    if (fit > FIT_CAP) begin
      fit = FIT_CAP;
    end
    return '{fitness: FIT_W'(fit), distance: DIST_W'(dist_sum), overlap: OVL_W'(ovl)};
  endfunction

  function automatic logic [STR_IN_W-1:0] pick_string();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2: return STR_IN_W'(1) << $urandom_range(STR_IN_W - 1);
      default: return STR_IN_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [5:0] r, input logic [5:0] c,
                           input logic [STR_IN_W-1:0] s);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({s, c, r});
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      for (int b = 0; b < BITS; b++) begin
        bit_pop[b] = bit_pop[b] - lattice[{r, c}][b] + s[b];
      end
      lattice[{r, c}] = s;
    end else begin
      pending.push_back(predict_fitness(r, c));
    end
  endtask

  // A load leaves no result behind, so allow its busy cycles after the queue drains.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_weights(input logic [WEIGHT_W-1:0] g, input logic [WEIGHT_W-1:0] a);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_GLOBAL;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_index <= CFG_LOCAL;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    weight_g = g;
    weight_a = a;
  endtask

  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    eval_result_t want;
    eval_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.fitness  = out_tdata[FIT_W-1:0];
      got.distance = out_tdata[FIT_W+DIST_W-1:FIT_W];
      got.overlap  = out_tdata[OUT_FIELDS_W-1:FIT_W+DIST_W];
      if (pending.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected result beat: fitness %0d distance %0d overlap %0d",
                   got.fitness, got.distance, got.overlap);
        end
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.fitness !== want.fitness || got.distance !== want.distance ||
            got.overlap !== want.overlap) begin
          if (errors < 10) begin
            $display("mismatch at %0t: fitness %0d/%0d distance %0d/%0d overlap %0d/%0d",
                     $realtime, want.fitness, got.fitness, want.distance, got.distance,
                     want.overlap, got.overlap);
          end
          errors++;
        end
      end
    end
  end

  // Nothing has been loaded yet, so every answer is zero under the reset weights.
  task automatic test_reset_state();
    send_item(OP_EVAL, 6'd0, 6'd0, '1);
    send_item(OP_EVAL, 6'd63, 6'd63, '0);
  endtask

  task automatic test_torus_wrap();
    send_item(OP_LOAD, 6'd0, 6'd0, '1);
    send_item(OP_LOAD, 6'd63, 6'd0, '1);
    send_item(OP_LOAD, 6'd1, 6'd0, '1);
    send_item(OP_LOAD, 6'd0, 6'd63, '1);
    send_item(OP_LOAD, 6'd0, 6'd1, '1);
    send_item(OP_EVAL, 6'd0, 6'd0, '0);
    send_item(OP_EVAL, 6'd63, 6'd63, '0);
    send_item(OP_EVAL, 6'd63, 6'd0, '0);
  endtask

  task automatic test_weight_extremes();
    set_weights('1, '1);
    send_item(OP_EVAL, 6'd0, 6'd0, '0);
    set_weights('0, '0);
    send_item(OP_EVAL, 6'd0, 6'd0, '0);
    set_weights('1, '0);
    send_item(OP_EVAL, 6'd0, 6'd63, '0);
    set_weights('0, '1);
    send_item(OP_EVAL, 6'd0, 6'd0, '0);
  endtask

  // Overwriting a cell must take its old bits out of the counts.
  task automatic test_single_bits();
    set_weights(16'd200, 16'd300);
    send_item(OP_LOAD, 6'd0, 6'd0, 16'h0001);
    send_item(OP_EVAL, 6'd0, 6'd0, '0);
    send_item(OP_LOAD, 6'd0, 6'd0, 16'h8000);
    send_item(OP_EVAL, 6'd0, 6'd1, '0);
    send_item(OP_LOAD, 6'd0, 6'd0, 16'h0000);
    send_item(OP_EVAL, 6'd0, 6'd0, '0);
    send_item(OP_EVAL, 6'd1, 6'd0, '0);
  endtask

  // Load a cell and some of its neighbors, then mostly evaluate the cell and at times the last neighbor loaded.
  task automatic test_clusters(input int beats);
    int          sent;
    logic [5:0]  r;
    logic [5:0]  c;
    logic [5:0]  nr;
    logic [5:0]  nc;
    int          k;
    sent = 0;
    while (sent < beats) begin
      r = 6'($urandom);
      c = 6'($urandom);
      nr = r;
      nc = c;
      if ($urandom_range(9) == 0) begin
        send_item(1'($urandom), r, c, STR_IN_W'($urandom));
        sent++;
      end else begin
        send_item(OP_LOAD, r, c, pick_string());
        sent++;
        k = $urandom_range(4);
        for (int i = 0; i < k; i++) begin
          nr = r;
          nc = c;
          case ($urandom_range(3))
            0: nr = r + 6'd1;
            1: nr = r - 6'd1;
            2: nc = c + 6'd1;
            default: nc = c - 6'd1;
          endcase
          send_item(OP_LOAD, nr, nc, pick_string());
          sent++;
        end
        if ($urandom_range(9) != 0) begin
          send_item(OP_EVAL, r, c, STR_IN_W'($urandom));
          sent++;
        end
        if ($urandom_range(3) == 0) begin
          send_item(OP_EVAL, nr, nc, STR_IN_W'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_noise(input int beats);
    for (int i = 0; i < beats; i++) begin
      send_item(1'($urandom), 6'($urandom), 6'($urandom), STR_IN_W'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears the whole lattice before it takes its first beat.
    do @(posedge clk); while (!in_tready);
    test_reset_state();
    test_torus_wrap();
    test_weight_extremes();
    test_single_bits();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom));
        1: set_weights('1, '1);
        2: set_weights('0, WEIGHT_W'($urandom));
        3: set_weights(WEIGHT_W'($urandom), '0);
        default: set_weights(WEIGHT_W'($urandom_range(511)), WEIGHT_W'($urandom_range(511)));
      endcase
      no_idle = (phase == 2);
      test_clusters(110);
      no_idle = 1'b0;
    end
    test_noise(70);
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("lattice_agent_fitness_tb: clean");
    end else begin
      $display("lattice_agent_fitness_tb: errors");
    end
    $finish;
  end

endmodule

// File: lattice_agent_fitness.f
+incdir+rtl/core
rtl/core/laf_pkg.sv
rtl/core/laf_datapath.sv
rtl/core/laf_ctrl.sv
rtl/core/lattice_agent_fitness.sv
tb/lattice_agent_fitness_tb.sv
